FILE: rtl/pls_pkg.sv
package pls_pkg;

    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REMOVE_AT  = 3'd2,
        CMD_REMOVE_VAL = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOB      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // What every cell does with its entry in the executing cycle
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_READ       = 3'd1,
        OP_INSERT     = 3'd2,
        OP_REMOVE_AT  = 3'd3,
        OP_REMOVE_VAL = 3'd4
    } op_t;

endpackage

FILE: rtl/positional_list_store.sv
// Channel   Handshake            Payload
// input     in_valid/in_ready    command, position, value
// output    out_valid/out_ready  status, read_data, entry_count, list_empty, is_full
//
// One command per cycle while out_ready is high; command and result are registered.
// The command register executes against all cells at once; the match and
// read-data chains ripple through the DEPTH cells within that cycle.
// Reset clears the count; entries are unwritten until inserted.
// With out_ready low the result holds and one more command is buffered.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [4:0]  position,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] read_data,
    output logic [4:0]  entry_count,
    output logic        list_empty,
    output logic        is_full
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic                  op_valid_reg;
    logic [2:0]            cmd_reg;
    logic [4:0]            pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [31:0]           read_data_reg;
    logic [4:0]            entry_count_reg;
    logic                  list_empty_reg;
    logic                  is_full_reg;

    logic                  exec_fire;
    logic                  in_fire;
    op_t                   op;
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;

    logic                  found [0:DEPTH];
    logic [DATA_WIDTH-1:0] rd    [0:DEPTH];
    logic [DATA_WIDTH-1:0] entry [0:DEPTH-1];

    assign exec_fire = op_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !op_valid_reg || exec_fire;
    assign in_fire   = in_valid && in_ready;
    assign pos_ext   = PW'(pos_reg);
    assign cnt_ext   = PW'(count_reg);

    assign found[0] = 1'b0;
    assign rd[0]    = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pls_cell #(
            .DW  (DATA_WIDTH),
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .en        (exec_fire),
            .op        (op),
            .pos       (pos_ext),
            .cnt       (cnt_ext),
            .val       (val_reg),
            .left      ((i == 0) ? val_reg : entry[(i == 0) ? 0 : i - 1]),
            .right     ((i == DEPTH - 1) ? val_reg : entry[(i == DEPTH - 1) ? i : i + 1]),
            .found_in  (found[i]),
            .rd_in     (rd[i]),
            .found_out (found[i+1]),
            .rd_out    (rd[i+1]),
            .entry     (entry[i])
        );
    end

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        op          = OP_HOLD;
        unique case (cmd_t'(cmd_reg))
            CMD_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_OOB;
                end
                else
                begin
                    op = OP_READ;
                end
            end
            CMD_INSERT:
            begin
                priority if (pos_ext > cnt_ext)
                begin
                    status_next = ST_OOB;
                end
                else if (count_reg == DEPTH_C)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op         = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_OOB;
                end
                else
                begin
                    op         = OP_REMOVE_AT;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_REMOVE_VAL:
            begin
                if (found[DEPTH])
                begin
                    op         = OP_REMOVE_VAL;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                op_valid_reg <= in_valid;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            val_reg <= DATA_WIDTH'(value);
        end
        if (exec_fire)
        begin
            status_reg      <= status_next;
            read_data_reg   <= 32'(rd[DEPTH]);
            entry_count_reg <= 5'(count_next);
            list_empty_reg  <= (count_next == '0);
            is_full_reg     <= (count_next == DEPTH_C);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_data   = read_data_reg;
    assign entry_count = entry_count_reg;
    assign list_empty  = list_empty_reg;
    assign is_full     = is_full_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (op == OP_INSERT) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && (status_next == ST_FULL) |-> count_reg == DEPTH_C)
        else $error("full status on a list that is not full");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_full_reg |-> !list_empty_reg)
        else $error("empty and full flagged together");
`endif

endmodule

FILE: rtl/pls_cell.sv
module pls_cell
    import pls_pkg::*;
#(
    parameter int DW  = 32,
    parameter int PW  = 5,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          en,
    input  op_t           op,
    input  logic [PW-1:0] pos,
    input  logic [PW-1:0] cnt,
    input  logic [DW-1:0] val,
    input  logic [DW-1:0] left,
    input  logic [DW-1:0] right,
    input  logic          found_in,
    input  logic [DW-1:0] rd_in,
    output logic          found_out,
    output logic [DW-1:0] rd_out,
    output logic [DW-1:0] entry
);

    localparam logic [PW-1:0] IDX_C = PW'(IDX);

    logic [DW-1:0] entry_reg;
    logic [DW-1:0] entry_next;
    logic          hit;

    assign entry     = entry_reg;
    assign hit       = (IDX_C < cnt) && (entry_reg == val);
    assign found_out = found_in | hit;
    assign rd_out    = rd_in | (((op == OP_READ) && (pos == IDX_C)) ? entry_reg : '0);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (IDX_C > pos)
                begin
                    entry_next = left;
                end
                else if (IDX_C == pos)
                begin
                    entry_next = val;
                end
            end
            OP_REMOVE_AT:
            begin
                if (IDX_C >= pos)
                begin
                    entry_next = right;
                end
            end
            OP_REMOVE_VAL:
            begin
                if (found_out)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule
